>>> sv/frp_pkg.sv
// Shared types and constants of the fixed-length frame receive parser.
// Depends on nothing; every other file of the parser refers to it by scoped name.
package frp_pkg;

  // Field widths of the byte channels
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;

  // Configuration register file
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 1'b1;
  localparam logic [CFG_DAT_W-1:0] HEADER_RST  = 8'hAA;
  localparam logic [CFG_DAT_W-1:0] TRAILER_RST = 8'h55;

  // Received byte item
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  // Emitted payload item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cnt_clr;  // restart the byte counter
    logic wr_en;    // store the received byte at the counter
    logic rd_en;    // read the store at the counter into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr_match;  // received byte equals the header register
    logic trl_match;  // received byte equals the trailer register
    logic cnt_last;   // counter points at the final payload slot
    logic out_free;   // output register is empty or transfers this cycle
  } dp_sts_t;

endpackage

>>> sv/frp_stream_if.sv
// Valid/ready stream channel used for received bytes and for payload results.
// Depends on frp_pkg for the default item type.
interface frp_stream_if #(
  parameter type T = frp_pkg::rx_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/frp_ctrl.sv
// Parser controller: hunt, collect, trailer check and emit sequencing.
// Depends on frp_pkg for the command and status structs.
module frp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  frp_pkg::dp_sts_t sts_i,
  output frp_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_DATA,
    ST_TAIL,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   rx_xfer;

  // Stall the receive side only while the stored frame is read out
  assign rx_ready_o = (state_q != ST_EMIT);
  assign rx_xfer    = rx_valid_i && rx_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    cmd_o.cnt_clr = 1'b0;
    cmd_o.wr_en   = 1'b0;
    cmd_o.rd_en   = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        if (rx_xfer && sts_i.hdr_match) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DATA;
        end
      end
      ST_DATA: begin
        if (rx_xfer) begin
          cmd_o.wr_en = 1'b1;
          if (sts_i.cnt_last) state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // A wrong trailer drops the frame; a good one starts the read-out
        if (rx_xfer) begin
          if (sts_i.trl_match) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.rd_en = 1'b1;
          if (sts_i.cnt_last) state_d = ST_HUNT;
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/frp_datapath.sv
// Parser datapath: configuration registers, byte counter, frame store and
// the output register. Depends on frp_pkg for item, command and status types.
module frp_datapath #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [frp_pkg::CFG_DAT_W-1:0]     cfg_wdata_i,
  input  logic [frp_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output frp_pkg::out_item_t                out_item_o,
  input  frp_pkg::dp_cmd_t                  cmd_i,
  output frp_pkg::dp_sts_t                  sts_o
);

  localparam int AddrW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int IdxW  = frp_pkg::IDX_W;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PAYLOAD_BYTES - 1);

  logic [frp_pkg::CFG_DAT_W-1:0] header_q, trailer_q;
  logic [AddrW-1:0]              cnt_q;
  logic [frp_pkg::BYTE_W-1:0]    mem_q [PAYLOAD_BYTES];
  logic [frp_pkg::BYTE_W-1:0]    rd_data_q;
  logic [IdxW-1:0]               idx_q;
  logic                          last_q;
  logic                          out_valid_q;

  // Write configuration registers; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= frp_pkg::HEADER_RST;
      trailer_q <= frp_pkg::TRAILER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frp_pkg::REG_HEADER:  header_q  <= cfg_wdata_i;
        frp_pkg::REG_TRAILER: trailer_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the shared write/read counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.wr_en || cmd_i.rd_en) begin
      cnt_q <= cnt_q + AddrW'(1);
    end
  end

  // Frame store with registered read; the read register is the output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cnt_q] <= rx_byte_i;
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cnt_q];
      idx_q     <= IdxW'(cnt_q);
      last_q    <= (cnt_q == LastAddr);
    end
  end

  // Hold the output until it transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_item_o.payload_byte = rd_data_q;
  assign out_item_o.byte_index   = idx_q;
  assign out_item_o.last_byte    = last_q;

  // Status toward the controller
  assign sts_o.hdr_match = (rx_byte_i == header_q);
  assign sts_o.trl_match = (rx_byte_i == trailer_q);
  assign sts_o.cnt_last  = (cnt_q == LastAddr);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> sv/fixed_frame_receive_parser.sv
// Top level of the fixed-length frame receive parser.
// Depends on frp_pkg, frp_stream_if, frp_ctrl and frp_datapath.
//
//   channel   dir  item            transfer when
//   rx_i      in   rx_byte         rx_i.valid && rx_i.ready
//   frame_o   out  payload_byte,   frame_o.valid && frame_o.ready
//                  byte_index,
//                  last_byte
//   cfg       in   header/trailer  cfg_we_i high
//
// A received byte is taken whenever rx_i.valid is high while hunting, collecting
// or checking the trailer. After a good trailer the frame store is read one
// entry per cycle, while frame_o is not stalled, through its single read port;
// rx_i.ready is low until the frame has drained. A stalled frame_o holds the
// read sequencer. Reset returns to hunting with header 0xAA and trailer 0x55;
// the frame store needs no clearing.
module fixed_frame_receive_parser #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  frp_stream_if.sink                    rx_i,
  frp_stream_if.source                  frame_o,
  input  logic                          cfg_we_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [frp_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);

  frp_pkg::dp_cmd_t   cmd;
  frp_pkg::dp_sts_t   sts;
  frp_pkg::out_item_t out_item;

  frp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frp_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.data.rx_byte),
    .out_ready_i (frame_o.ready),
    .out_valid_o (frame_o.valid),
    .out_item_o  (out_item),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign frame_o.data = out_item;

  // The receive side is closed whenever the store is being read out
  a_no_rx_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !rx_i.ready)
    else $error("byte accepted during frame read-out");

  // The store port never writes and reads in the same cycle
  a_no_wr_rd_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && cmd.rd_en))
    else $error("frame store written and read together");

  // A read always lands in the output register on the next cycle
  a_read_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |=> frame_o.valid)
    else $error("read issued but no result presented");

endmodule

>>> tb/tb_fixed_frame_receive_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_frame_receive_parser: streams received bytes, predicts
// the emitted payload runs in a local frame parser and compares every transfer on frame_o.
// Depends on frp_pkg, frp_stream_if and the parser RTL.
module tb_fixed_frame_receive_parser;

  localparam int PAYLOAD_BYTES = 32;
  localparam int MAX_WAIT      = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int RAND_PHASES   = 3;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_TRAILER
  } parse_phase_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  logic                          cfg_we    = 1'b0;
  logic [frp_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [frp_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  frp_stream_if #(.T(frp_pkg::rx_item_t))  rx_if ();
  frp_stream_if #(.T(frp_pkg::out_item_t)) frame_if ();

  fixed_frame_receive_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_i       (rx_if),
    .frame_o    (frame_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Parser shadow state and register copies
  parse_phase_e   parse_phase = PH_HUNT;
  int             byte_count  = 0;
  logic [7:0]     frame_copy [PAYLOAD_BYTES];
  logic [7:0]     header_reg  = frp_pkg::HEADER_RST;
  logic [7:0]     trailer_reg = frp_pkg::TRAILER_RST;

  frp_pkg::rx_item_t  rx_pending_q[$];
  frp_pkg::out_item_t expected_payload_q[$];
  frp_pkg::out_item_t want_item;

  int  rx_pushed       = 0;
  int  rx_accepted     = 0;
  int  framed_bytes    = 0;
  int  good_frames     = 0;
  int  dropped_frames  = 0;
  int  payload_checked = 0;
  int  error_count     = 0;
  int  stall_cycles    = 0;
  int  rx_wait         = 0;
  int  out_wait        = 0;
  bit  rx_idle_en      = 1'b1;
  bit  out_idle_en     = 1'b1;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Advance the shadow parser by one received byte; queue the payload run on a good trailer
  task automatic parse_rx_byte(input logic [7:0] rx_val);
    frp_pkg::out_item_t item;
    int                 k;
    case (parse_phase)
      PH_COLLECT: begin
        if (byte_count < PAYLOAD_BYTES) begin
          frame_copy[byte_count] = rx_val;
          byte_count++;
        end
        if (byte_count >= PAYLOAD_BYTES) parse_phase = PH_TRAILER;
      end
      PH_TRAILER: begin
        if (rx_val == trailer_reg) begin
          for (k = 0; k < PAYLOAD_BYTES; k++) begin
            item.payload_byte = frame_copy[k];
            item.byte_index   = k[frp_pkg::IDX_W-1:0];
            item.last_byte    = (k == PAYLOAD_BYTES - 1);
            expected_payload_q.push_back(item);
          end
          good_frames++;
        end else begin
          dropped_frames++;
        end
        parse_phase = PH_HUNT;
      end
      default: begin
        if (rx_val == header_reg) begin
          byte_count  = 0;
          parse_phase = PH_COLLECT;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] rx_val);
    frp_pkg::rx_item_t item;
    item.rx_byte = rx_val;
    rx_pending_q.push_back(item);
    rx_pushed++;
  endtask

  // Queue noise, a header, a payload with random content and a good or bad trailer
  task automatic push_frame(input bit good_tail, input int noise_len);
    logic [7:0] v;
    int         k;
    repeat (noise_len) begin
      do v = 8'($urandom_range(0, 255)); while (v == header_reg);
      push_byte(v);
    end
    push_byte(header_reg);
    for (k = 0; k < PAYLOAD_BYTES; k++) begin
      case ($urandom_range(0, 7))
        0:       v = header_reg;
        1:       v = trailer_reg;
        default: v = 8'($urandom_range(0, 255));
      endcase
      push_byte(v);
    end
    if (good_tail) begin
      push_byte(trailer_reg);
    end else begin
      do v = 8'($urandom_range(0, 255)); while (v == trailer_reg);
      push_byte(v);
    end
    framed_bytes += PAYLOAD_BYTES + 2;
  endtask

  // Hold until every queued byte is taken and every payload byte has come out
  task automatic wait_drained();
    while (rx_accepted != rx_pushed || expected_payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [frp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == frp_pkg::REG_HEADER) header_reg = value;
    else trailer_reg = value;
  endtask

  // Received byte driver: one transfer per item, random gap after each when rx_idle_en is set
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_if.valid <= 1'b0;
      rx_if.data  <= '0;
      rx_wait      = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_rx_byte(rx_if.data.rx_byte);
        rx_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_wait > 0) begin
          rx_wait--;
          rx_if.valid <= 1'b0;
        end else if (rx_pending_q.size() > 0) begin
          rx_if.data  <= rx_pending_q.pop_front();
          rx_if.valid <= 1'b1;
          rx_wait      = rx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Payload monitor: random stalls on ready when out_idle_en is set, check each transfer against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      frame_if.ready <= 1'b0;
      out_wait        = 0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        if (expected_payload_q.size() == 0) begin
          report_mismatch($sformatf("payload byte %02h index %0d with nothing pending",
                                    frame_if.data.payload_byte, frame_if.data.byte_index));
        end else begin
          want_item = expected_payload_q.pop_front();
          if (frame_if.data.payload_byte !== want_item.payload_byte)
            report_mismatch($sformatf("payload_byte got %02h exp %02h at index %0d",
                                      frame_if.data.payload_byte, want_item.payload_byte,
                                      want_item.byte_index));
          if (frame_if.data.byte_index !== want_item.byte_index)
            report_mismatch($sformatf("byte_index got %0d exp %0d",
                                      frame_if.data.byte_index, want_item.byte_index));
          if (frame_if.data.last_byte !== want_item.last_byte)
            report_mismatch($sformatf("last_byte got %b exp %b at index %0d",
                                      frame_if.data.last_byte, want_item.last_byte,
                                      want_item.byte_index));
          payload_checked++;
        end
        out_wait = out_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (out_wait > 0) begin
        out_wait--;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_fixed_frame_receive_parser: FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] hv, tv, v;
    int         p, k, sel, nfr, pause_frame, phase_start, len, fill;

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset header/trailer values, noise while hunting
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(frp_pkg::TRAILER_RST);
    // Extremes and header/trailer values inside the payload, walking bits for the rest
    push_byte(frp_pkg::HEADER_RST);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(frp_pkg::HEADER_RST);
    push_byte(frp_pkg::HEADER_RST);
    push_byte(frp_pkg::TRAILER_RST);
    for (k = 5; k < PAYLOAD_BYTES; k++)
      push_byte(8'(1 << (k % 8)) ^ ((k >= 16) ? 8'hFF : 8'h00));
    push_byte(frp_pkg::TRAILER_RST);
    framed_bytes += PAYLOAD_BYTES + 2;
    // Bad trailer equal to the header value must not start a new frame
    push_byte(frp_pkg::HEADER_RST);
    for (k = 0; k < PAYLOAD_BYTES; k++) push_byte(8'($urandom_range(0, 255)));
    push_byte(frp_pkg::HEADER_RST);
    push_byte(8'h01);
    framed_bytes += PAYLOAD_BYTES + 2;
    // Back-to-back frame, payload opening with the header value
    push_byte(frp_pkg::HEADER_RST);
    push_byte(frp_pkg::HEADER_RST);
    for (k = 1; k < PAYLOAD_BYTES; k++) push_byte(8'hFF);
    push_byte(frp_pkg::TRAILER_RST);
    framed_bytes += PAYLOAD_BYTES + 2;
    wait_drained();

    // Random: one header/trailer setting per phase, mostly well-formed frames
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       begin hv = 8'h00; tv = 8'hFF; end
        1:       begin hv = 8'hFF; tv = 8'h00; end
        2:       begin hv = 8'h5A; tv = 8'h5A; end
        default: begin hv = 8'($urandom_range(0, 255)); tv = 8'($urandom_range(0, 255)); end
      endcase
      rx_idle_en  = (p == 0) || (p == 2);
      out_idle_en = (p == 0) || (p == 1);
      write_cfg(frp_pkg::REG_HEADER, hv);
      write_cfg(frp_pkg::REG_TRAILER, tv);

      phase_start = framed_bytes;
      nfr         = 0;
      pause_frame = $urandom_range(1, 2);
      while (framed_bytes - phase_start < PAYLOAD_BYTES) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          push_frame(1'b1, $urandom_range(0, 3));
        end else if (sel < 9) begin
          push_frame(1'b0, $urandom_range(0, 3));
        end else begin
          // Broken sequence: random bytes rich in header values
          len = $urandom_range(4, 20);
          repeat (len) begin
            v = ($urandom_range(0, 3) == 0) ? header_reg : 8'($urandom_range(0, 255));
            push_byte(v);
          end
          framed_bytes += len;
        end
        nfr++;
        if (nfr == pause_frame) wait_drained();
      end
      wait_drained();

      // Finish any partial frame so the next register write sees the parser hunting
      if (parse_phase == PH_COLLECT) fill = PAYLOAD_BYTES - byte_count + 1;
      else if (parse_phase == PH_TRAILER) fill = 1;
      else fill = 0;
      repeat (fill) push_byte(8'($urandom_range(0, 255)));
      wait_drained();
    end

    $display("Sent %0d received bytes under %0d header/trailer settings, idle and busy.",
             rx_accepted, RAND_PHASES + 1);
    $display("Accepted %0d frames, dropped %0d on a bad trailer, checked %0d payload bytes.",
             good_frames, dropped_frames, payload_checked);
    if (error_count == 0) begin
      $display("tb_fixed_frame_receive_parser: PASS");
    end else begin
      $display("tb_fixed_frame_receive_parser: FAIL");
    end
    $finish;
  end

endmodule
